// ===== rtl/core/bqc_pkg.sv =====
// Package for the biquad cascade filter: widths, coefficient set type,
// controller types and the rounding/saturation helper.
// No dependencies; every other file of the block imports it.
`default_nettype none

package bqc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int FF_W      = 3 * COEF_W;
  localparam int FB_W      = 2 * COEF_W;
  localparam int PROD_W    = COEF_W + SAMPLE_W;
  localparam int ACC_W     = PROD_W + 3;
  localparam int RND_SHIFT = 15;
  localparam int RND_W     = ACC_W - RND_SHIFT;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = FF_W;
  localparam int CNT_W     = 3;

  localparam int CHANNELS_DEFAULT = 2;

  // b0 = 1.0 in Q3.15, all other taps zero: the filter passes samples through.
  localparam logic [FF_W-1:0] FF_RESET = FF_W'(32768);
  localparam logic [FB_W-1:0] FB_RESET = '0;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(16384);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_S1_FF = 3'd0,
    CFG_S1_FB = 3'd1,
    CFG_S2_FF = 3'd2,
    CFG_S2_FB = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [FF_W-1:0] s1_ff;
    logic [FB_W-1:0] s1_fb;
    logic [FF_W-1:0] s2_ff;
    logic [FB_W-1:0] s2_fb;
  } coef_set_t;

  // Taps in the order the MAC walks through them.
  typedef enum logic [CNT_W-1:0] {
    TERM_B0 = 3'd0,
    TERM_B1 = 3'd1,
    TERM_B2 = 3'd2,
    TERM_A1 = 3'd3,
    TERM_A2 = 3'd4
  } term_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_MAC1 = 3'd1,
    ST_RND1 = 3'd2,
    ST_MAC2 = 3'd3,
    ST_RND2 = 3'd4
  } ctrl_state_e;

  typedef struct packed {
    logic  capture;
    logic  stage;
    term_e term;
    logic  acc_en;
    logic  acc_load;
    logic  acc_sub;
    logic  mid_en;
    logic  res_en;
  } ctrl_cmd_t;

  // Round half up to Q1.15 and clamp to the 16-bit range.
  function automatic logic signed [SAMPLE_W-1:0] round_sat(
      input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] biased;
    logic signed [RND_W-1:0] rnd;
    biased = acc + ROUND_BIAS;
    rnd = biased[ACC_W-1:RND_SHIFT];
    if (rnd > RND_W'(SAMPLE_MAX)) begin
      return SAMPLE_MAX;
    end else if (rnd < RND_W'(SAMPLE_MIN)) begin
      return SAMPLE_MIN;
    end
    return rnd[SAMPLE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bqc_intf.sv =====
// Channel interfaces of the biquad cascade filter: sample input,
// filtered output and coefficient write port. Depends on bqc_pkg.
`default_nettype none

interface bqc_in_if;
  import bqc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       channel;
  logic signed [SAMPLE_W-1:0] sample_in;
  modport source (output valid, channel, sample_in, input ready);
  modport sink (input valid, channel, sample_in, output ready);
endinterface

interface bqc_out_if;
  import bqc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       channel_out;
  logic signed [SAMPLE_W-1:0] sample_out;
  modport source (output valid, channel_out, sample_out, input ready);
  modport sink (input valid, channel_out, sample_out, output ready);
endinterface

interface bqc_cfg_if;
  import bqc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/biquad_cascade_filter.sv =====
// Fourth-order IIR filter: two direct-form-I biquads in cascade with one
// history set per channel. A new sample is accepted only after the result
// of the previous one has been written to the output register; this is set
// by the single shared 18x16 multiply-accumulate unit, which computes the
// ten products of both stages one per cycle. A result waits in an output
// register, so a stalled output delays only the end of the next sample.
// Coefficients are Q3.15 and should be written while idle.
// Depends on bqc_pkg, bqc_intf, bqc_cfg_regs, bqc_ctrl and bqc_datapath.
`default_nettype none

module biquad_cascade_filter #(
  parameter int CHANNELS = bqc_pkg::CHANNELS_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bqc_in_if.sink    in_i,
  bqc_out_if.source out_o,
  bqc_cfg_if.sink   cfg_i
);
  import bqc_pkg::*;

  coef_set_t coef;
  ctrl_cmd_t cmd;
  logic      in_ready;
  logic      out_valid;

  bqc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .coef_o (coef)
  );

  bqc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  bqc_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .coef_i    (coef),
    .channel_i (in_i.channel),
    .sample_i  (in_i.sample_in),
    .channel_o (out_o.channel_out),
    .sample_o  (out_o.sample_out)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

`default_nettype wire

// ===== rtl/core/bqc_cfg_regs.sv =====
// Coefficient register bank of the biquad cascade filter.
// Depends on bqc_pkg and bqc_intf.
`default_nettype none

module bqc_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  bqc_cfg_if.sink             cfg_i,
  output bqc_pkg::coef_set_t  coef_o
);
  import bqc_pkg::*;

  coef_set_t coef_q;

  assign cfg_i.ready = 1'b1;
  assign coef_o      = coef_q;

  // Writes to an index past the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.s1_ff <= FF_RESET;
      coef_q.s1_fb <= FB_RESET;
      coef_q.s2_ff <= FF_RESET;
      coef_q.s2_fb <= FB_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_S1_FF: coef_q.s1_ff <= cfg_i.data;
        CFG_S1_FB: coef_q.s1_fb <= cfg_i.data[FB_W-1:0];
        CFG_S2_FF: coef_q.s2_ff <= cfg_i.data;
        CFG_S2_FB: coef_q.s2_fb <= cfg_i.data[FB_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bqc_ctrl.sv =====
// Sequencing controller of the biquad cascade filter: walks the shared
// MAC through both stages and owns the handshakes. Depends on bqc_pkg.
`default_nettype none

module bqc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bqc_pkg::ctrl_cmd_t cmd_o
);
  import bqc_pkg::*;

  // Five products, each accumulated in the cycle after the multiplier forms it.
  localparam logic [CNT_W-1:0] MacLast  = CNT_W'(5);
  localparam logic [CNT_W-1:0] TermLast = CNT_W'(4);

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  ctrl_cmd_t        cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd        = '0;
    cmd.term   = TERM_B0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          cnt_d       = '0;
          state_d     = ST_MAC1;
        end
      end
      ST_MAC1, ST_MAC2: begin
        cmd.stage = (state_q == ST_MAC2);
        if (cnt_q <= TermLast) begin
          cmd.term = term_e'(cnt_q);
        end
        cmd.acc_en   = (cnt_q != '0);
        cmd.acc_load = (cnt_q == CNT_W'(1));
        // The product in flight belongs to a feedback tap.
        cmd.acc_sub  = (cnt_q > CNT_W'(TERM_A1));
        if (cnt_q == MacLast) begin
          cnt_d   = '0;
          state_d = (state_q == ST_MAC1) ? ST_RND1 : ST_RND2;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_RND1: begin
        cmd.mid_en = 1'b1;
        state_d    = ST_MAC2;
      end
      ST_RND2: begin
        cmd.stage = 1'b1;
        // Hold the finished result until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd.res_en = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd.res_en | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  a_accept_starts_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> (state_q == ST_MAC1) && (cnt_q == '0))
    else $error("accepted sample did not start stage 1");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_en |-> (!out_valid_q || out_ready_i))
    else $error("result written over an untaken output");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_en |=> out_valid_q)
    else $error("result register not marked valid");

  a_idle_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cnt_q == '0))
    else $error("tap counter not cleared at idle");

endmodule

`default_nettype wire

// ===== rtl/core/bqc_datapath.sv =====
// Datapath of the biquad cascade filter: per-channel history, one shared
// 18x16 multiplier with accumulator, rounding and the output register.
// Depends on bqc_pkg.
`default_nettype none

module bqc_datapath #(
  parameter int CHANNELS = bqc_pkg::CHANNELS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bqc_pkg::ctrl_cmd_t                  cmd_i,
  input  bqc_pkg::coef_set_t                  coef_i,
  input  logic                                channel_i,
  input  logic signed [bqc_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                channel_o,
  output logic signed [bqc_pkg::SAMPLE_W-1:0] sample_o
);
  import bqc_pkg::*;

  localparam int HistW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic                       chan_q;
  logic [HistW-1:0]           hidx_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [SAMPLE_W-1:0] mid_q;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [ACC_W-1:0]    addend;
  logic signed [SAMPLE_W-1:0] rnd_val;
  logic                       out_chan_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;

  // Stage 2 reads the stage 1 output history as its input history.
  logic signed [SAMPLE_W-1:0] in_p1_q  [CHANNELS];
  logic signed [SAMPLE_W-1:0] in_p2_q  [CHANNELS];
  logic signed [SAMPLE_W-1:0] mid_p1_q [CHANNELS];
  logic signed [SAMPLE_W-1:0] mid_p2_q [CHANNELS];
  logic signed [SAMPLE_W-1:0] out_p1_q [CHANNELS];
  logic signed [SAMPLE_W-1:0] out_p2_q [CHANNELS];

  logic [FF_W-1:0]            ff_sel;
  logic [FB_W-1:0]            fb_sel;
  logic signed [COEF_W-1:0]   coef_sel;
  logic signed [SAMPLE_W-1:0] op_sel;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      chan_q <= channel_i;
      hidx_q <= (CHANNELS > 1) ? HistW'(channel_i) : '0;
      x_q    <= sample_i;
    end
  end

  always_comb begin
    ff_sel = cmd_i.stage ? coef_i.s2_ff : coef_i.s1_ff;
    fb_sel = cmd_i.stage ? coef_i.s2_fb : coef_i.s1_fb;
    case (cmd_i.term)
      TERM_B0: begin
        coef_sel = ff_sel[0*COEF_W +: COEF_W];
        op_sel   = cmd_i.stage ? mid_q : x_q;
      end
      TERM_B1: begin
        coef_sel = ff_sel[1*COEF_W +: COEF_W];
        op_sel   = cmd_i.stage ? mid_p1_q[hidx_q] : in_p1_q[hidx_q];
      end
      TERM_B2: begin
        coef_sel = ff_sel[2*COEF_W +: COEF_W];
        op_sel   = cmd_i.stage ? mid_p2_q[hidx_q] : in_p2_q[hidx_q];
      end
      TERM_A1: begin
        coef_sel = fb_sel[0*COEF_W +: COEF_W];
        op_sel   = cmd_i.stage ? out_p1_q[hidx_q] : mid_p1_q[hidx_q];
      end
      TERM_A2: begin
        coef_sel = fb_sel[1*COEF_W +: COEF_W];
        op_sel   = cmd_i.stage ? out_p2_q[hidx_q] : mid_p2_q[hidx_q];
      end
      default: begin
        coef_sel = '0;
        op_sel   = '0;
      end
    endcase
  end

  assign prod_d = coef_sel * op_sel;
  assign addend = ACC_W'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_load) begin
      acc_d = addend;
    end else if (cmd_i.acc_sub) begin
      acc_d = acc_q - addend;
    end else begin
      acc_d = acc_q + addend;
    end
  end

  assign rnd_val = round_sat(acc_q);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.acc_en) begin
      acc_q <= acc_d;
    end
    if (cmd_i.mid_en) begin
      mid_q <= rnd_val;
    end
    if (cmd_i.res_en) begin
      out_chan_q   <= chan_q;
      out_sample_q <= rnd_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        in_p1_q[c]  <= '0;
        in_p2_q[c]  <= '0;
        mid_p1_q[c] <= '0;
        mid_p2_q[c] <= '0;
        out_p1_q[c] <= '0;
        out_p2_q[c] <= '0;
      end
    end else if (cmd_i.res_en) begin
      in_p2_q[hidx_q]  <= in_p1_q[hidx_q];
      in_p1_q[hidx_q]  <= x_q;
      mid_p2_q[hidx_q] <= mid_p1_q[hidx_q];
      mid_p1_q[hidx_q] <= mid_q;
      out_p2_q[hidx_q] <= out_p1_q[hidx_q];
      out_p1_q[hidx_q] <= rnd_val;
    end
  end

  assign channel_o = out_chan_q;
  assign sample_o  = out_sample_q;

endmodule

`default_nettype wire

// ===== sim/biquad_cascade_filter_tb.sv =====
// Self-checking testbench for biquad_cascade_filter: a directed table, then
// randomized coefficient phases with random idling on both sides.
// Depends on bqc_pkg, bqc_intf and the filter RTL.
`default_nettype none

module biquad_cascade_filter_tb;
  import bqc_pkg::*;

  localparam int HOLD_CYCLES      = 300;
  localparam int ITEMS_PER_PHASE  = 140;
  localparam int RANDOM_PHASES    = 8;
  localparam int SETTLE_CYCLES    = 30;
  localparam int MAX_PRINTED      = 40;
  localparam int FIRST_UNUSED_IDX = int'(CFG_S2_FB) + 1;
  localparam int LAST_IDX         = 2 ** CFG_IDX_W - 1;

  localparam logic [COEF_W-1:0] COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [COEF_W-1:0] COEF_HALF = COEF_W'(16384);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_e;
  typedef enum logic [1:0] {COEF_MILD, COEF_FULL, COEF_EDGE} coef_style_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    logic                  channel;
    sample_t               sample;
    logic                  known;
    sample_t               result;
  } stim_row_t;

  typedef struct packed {
    logic    channel;
    sample_t sample;
  } filtered_t;

  logic clk_i;
  logic rst_ni;

  bqc_in_if  in_if ();
  bqc_out_if out_if ();
  bqc_cfg_if cfg_if ();

  biquad_cascade_filter uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Mirror of the coefficient registers and the per-channel history.
  logic [FF_W-1:0] s1_ff_m, s2_ff_m;
  logic [FB_W-1:0] s1_fb_m, s2_fb_m;
  sample_t x_d1[CHANNELS_DEFAULT], x_d2[CHANNELS_DEFAULT];
  sample_t mid_d1[CHANNELS_DEFAULT], mid_d2[CHANNELS_DEFAULT];
  sample_t y_d1[CHANNELS_DEFAULT], y_d2[CHANNELS_DEFAULT];

  filtered_t expected_q[$];
  stim_row_t directed_q[$];

  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  function automatic longint tap(input logic [FF_W-1:0] bank, input int k);
    logic signed [COEF_W-1:0] c;
    c = bank[k*COEF_W +: COEF_W];
    return longint'(c);
  endfunction

  // One section: exact accumulation, round half up, clamp to 16 bits.
  function automatic sample_t section_out(input logic [FF_W-1:0] ff,
                                          input logic [FB_W-1:0] fb,
                                          input sample_t x0, input sample_t x1,
                                          input sample_t x2, input sample_t y1,
                                          input sample_t y2);
    longint acc;
    longint q;
    acc = tap(ff, 0) * longint'(x0) + tap(ff, 1) * longint'(x1)
        + tap(ff, 2) * longint'(x2) - tap(FF_W'(fb), 0) * longint'(y1)
        - tap(FF_W'(fb), 1) * longint'(y2);
    q = (acc + 64'sd16384) >>> RND_SHIFT;
    if (q > 32767) begin
      q = 32767;
    end else if (q < -32768) begin
      q = -32768;
    end
    return sample_t'(q);
  endfunction

  function automatic sample_t filter_sample(input logic ch, input sample_t x);
    int h;
    sample_t mid;
    sample_t y;
    h = int'(ch) % CHANNELS_DEFAULT;
    mid = section_out(s1_ff_m, s1_fb_m, x, x_d1[h], x_d2[h], mid_d1[h], mid_d2[h]);
    y = section_out(s2_ff_m, s2_fb_m, mid, mid_d1[h], mid_d2[h], y_d1[h], y_d2[h]);
    x_d2[h] = x_d1[h];
    x_d1[h] = x;
    mid_d2[h] = mid_d1[h];
    mid_d1[h] = mid;
    y_d2[h] = y_d1[h];
    y_d1[h] = y;
    return y;
  endfunction

  function automatic void add_sample(input logic ch, input sample_t smp,
                                     input logic known, input sample_t res);
    stim_row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.channel = ch;
    r.sample = smp;
    r.known = known;
    r.result = res;
    directed_q.push_back(r);
  endfunction

  function automatic void add_config(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CONFIG;
    r.index = idx;
    r.data = val;
    directed_q.push_back(r);
  endfunction

  function automatic logic [COEF_W-1:0] pick_tap(input coef_style_e style,
                                                 input int lim);
    case (style)
      COEF_FULL: return COEF_W'($urandom);
      COEF_EDGE: begin
        case ($urandom_range(0, 3))
          0: return COEF_MAX;
          1: return COEF_MIN;
          2: return '0;
          default: return COEF_W'($urandom);
        endcase
      end
      default: return COEF_W'(int'($urandom_range(0, 2 * lim)) - lim);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_ff(input coef_style_e style);
    logic [CFG_DATA_W-1:0] v;
    for (int k = 0; k < 3; k++) begin
      v[k*COEF_W +: COEF_W] = pick_tap(style, 20000);
    end
    return v;
  endfunction

  // The bits above the two feedback taps are random; the register drops them.
  function automatic logic [CFG_DATA_W-1:0] pick_fb(input coef_style_e style);
    logic [CFG_DATA_W-1:0] v;
    int a2;
    int lim;
    v = CFG_DATA_W'({$urandom, $urandom});
    if (style == COEF_MILD) begin
      // Keep the poles inside the unit circle so the output stays lively.
      a2 = int'($urandom_range(0, 36000)) - 12000;
      lim = 32768 + a2 - 3000;
      v[COEF_W-1:0] = COEF_W'(int'($urandom_range(0, 2 * lim)) - lim);
      v[2*COEF_W-1:COEF_W] = COEF_W'(a2);
    end else begin
      v[COEF_W-1:0] = pick_tap(style, 0);
      v[2*COEF_W-1:COEF_W] = pick_tap(style, 0);
    end
    return v;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      1, 2, 3: return sample_t'(int'($urandom_range(0, 600)) - 300);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic push_sample(input logic ch, input sample_t smp,
                             input logic known, input sample_t res);
    filtered_t want;
    // A configuration write may have left its valid high.
    cfg_if.valid <= 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.channel <= ch;
    in_if.sample_in <= smp;
    do @(posedge clk_i); while (!in_if.ready);
    want.channel = ch;
    want.sample = filter_sample(ch, smp);
    if (known) begin
      want.sample = res;
    end
    expected_q.push_back(want);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_S1_FF: s1_ff_m = val;
      CFG_S1_FB: s1_fb_m = val[FB_W-1:0];
      CFG_S2_FF: s2_ff_m = val;
      CFG_S2_FB: s2_fb_m = val[FB_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    cfg_if.valid <= 1'b0;
    while (expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (2) @(posedge clk_i);
  endtask

  task automatic load_random_coefs(input coef_style_e style);
    write_reg(CFG_S1_FF, pick_ff(style));
    write_reg(CFG_S1_FB, pick_fb(style));
    write_reg(CFG_S2_FF, pick_ff(style));
    write_reg(CFG_S2_FB, pick_fb(style));
  endtask

  // Output side: checks each transfer in order and drives ready.
  initial begin : result_sink
    int hold_left;
    int holds_seen;
    filtered_t got;
    filtered_t want;
    hold_left = 0;
    holds_seen = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.channel = out_if.channel_out;
        got.sample = out_if.sample_out;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result ch=%0d sample=%0d",
                                    got.channel, got.sample));
        end else begin
          want = expected_q.pop_front();
          if (got.channel !== want.channel) begin
            report_mismatch($sformatf("channel_out %0d, want %0d",
                                      got.channel, want.channel));
          end
          if (got.sample !== want.sample) begin
            report_mismatch($sformatf("sample_out %0d, want %0d (ch %0d)",
                                      got.sample, want.sample, want.channel));
          end
        end
      end
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    coef_style_e style;
    int sel;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests = 0;
    s1_ff_m = FF_RESET;
    s1_fb_m = FB_RESET;
    s2_ff_m = FF_RESET;
    s2_fb_m = FB_RESET;
    for (int c = 0; c < CHANNELS_DEFAULT; c++) begin
      x_d1[c] = '0;
      x_d2[c] = '0;
      mid_d1[c] = '0;
      mid_d2[c] = '0;
      y_d1[c] = '0;
      y_d2[c] = '0;
    end
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.channel <= 1'b0;
    in_if.sample_in <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;

    // After reset both sections pass samples straight through.
    add_sample(1'b0, SAMPLE_MAX, 1'b1, SAMPLE_MAX);
    add_sample(1'b1, SAMPLE_MIN, 1'b1, SAMPLE_MIN);
    add_sample(1'b0, 16'sd0, 1'b1, 16'sd0);
    add_sample(1'b1, -16'sd1, 1'b1, -16'sd1);
    // Writes to indexes past the register list must not change anything.
    for (int i = FIRST_UNUSED_IDX; i <= LAST_IDX; i++) begin
      add_config(CFG_IDX_W'(i), '1);
    end
    add_sample(1'b0, 16'sd1, 1'b1, 16'sd1);
    add_sample(1'b1, -16'sd2, 1'b1, -16'sd2);
    // Largest positive b0 saturates full-scale inputs.
    add_config(CFG_S1_FF, CFG_DATA_W'(COEF_MAX));
    add_sample(1'b0, SAMPLE_MAX, 1'b1, SAMPLE_MAX);
    add_sample(1'b1, SAMPLE_MIN, 1'b1, SAMPLE_MIN);
    add_sample(1'b0, 16'sd0, 1'b1, 16'sd0);
    // Most negative b0 flips full-scale inputs into the opposite rail.
    add_config(CFG_S1_FF, CFG_DATA_W'(COEF_MIN));
    add_sample(1'b0, SAMPLE_MIN, 1'b1, SAMPLE_MAX);
    add_sample(1'b1, SAMPLE_MAX, 1'b1, SAMPLE_MIN);
    add_sample(1'b0, -16'sd1, 1'b0, '0);
    // b0 = 0.5 puts odd inputs on exact halves, which round up.
    add_config(CFG_S1_FF, CFG_DATA_W'(COEF_HALF));
    add_sample(1'b1, 16'sd1, 1'b1, 16'sd1);
    add_sample(1'b1, -16'sd1, 1'b1, 16'sd0);
    add_sample(1'b0, 16'sd3, 1'b1, 16'sd2);
    add_sample(1'b0, -16'sd3, 1'b1, -16'sd1);
    // Every feedback tap and every stage 2 feedforward tap at a rail; stage 1 b0 is back at 1.0.
    add_config(CFG_S1_FF, FF_RESET);
    add_config(CFG_S1_FB, CFG_DATA_W'({COEF_MAX, COEF_MIN}));
    add_config(CFG_S2_FF, {COEF_MIN, COEF_MIN, COEF_MIN});
    add_config(CFG_S2_FB, CFG_DATA_W'({COEF_MIN, COEF_MAX}));
    add_sample(1'b0, SAMPLE_MAX, 1'b0, '0);
    add_sample(1'b1, SAMPLE_MIN, 1'b0, '0);
    add_sample(1'b0, SAMPLE_MIN, 1'b0, '0);
    add_sample(1'b1, SAMPLE_MAX, 1'b0, '0);
    add_sample(1'b0, 16'sd0, 1'b0, '0);
    add_sample(1'b1, 16'sd0, 1'b0, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) begin
      row = directed_q[i];
      if (row.kind == ROW_CONFIG) begin
        drain();
        write_reg(row.index, row.data);
      end else begin
        push_sample(row.channel, row.sample, row.known, row.result);
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      sel = (phase + phase / 4) % 4;
      style = (sel == 1) ? COEF_FULL : (sel == 3) ? COEF_EDGE : COEF_MILD;
      load_random_coefs(style);
      if (phase == 3) begin
        write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_IDX, LAST_IDX)),
                  CFG_DATA_W'({$urandom, $urandom}));
      end
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 65;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 65;
        end
        default: begin
          send_idle_pct = 19;
          recv_stall_pct = 19;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // The output holds off while samples keep coming, so the input backs up.
        if (phase == 4 && n == 20) begin
          hold_requests++;
        end
        if (phase == 5 && n == 70) begin
          drain();
        end
        push_sample(1'($urandom_range(0, 1)), pick_sample(), 1'b0, '0);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
